[rtl/mog_pkg.sv]
// Shared types and constants for the motion oscillation guard.
`timescale 1ns / 1ps

package mog_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIST_SQ_W  = 46;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_ANGLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TIME     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRAFE_GATE    = 2'd3;

    localparam logic [23:0]          RST_RESET_DISTANCE = 24'sd50;
    localparam logic [15:0]          RST_RESET_ANGLE    = 16'sd200;
    localparam logic [31:0]          RST_RESET_TIME     = 32'hFFFF_FFFF;
    localparam logic [15:0]          RST_STRAFE_GATE    = 16'sd50;
    localparam logic [DIST_SQ_W-1:0] RST_DIST_SQ        = 46'd2500;

    localparam int MODE_COMMIT = 0;
    localparam int MODE_SCORE  = 1;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } t_sign;

    typedef struct packed {
        logic               mode;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [15:0] pose_heading;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_turn;
        logic        [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic signed [23:0]     reset_distance;
        logic signed [15:0]     reset_angle;
        logic signed [31:0]     reset_time;
        logic signed [15:0]     strafe_gate;
        logic [DIST_SQ_W-1:0]   dist_sq;
    } t_cfg;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] heading;
        logic        [31:0] time_ms;
    } t_ref;

    typedef struct packed {
        logic       rejected;
        logic       flag_newly_set;
        logic       flags_cleared;
        logic [5:0] restrictions;
    } t_result;

endpackage

[rtl/motion_oscillation_guard.sv]
// Top level of the motion oscillation guard: configuration registers and handshake.
// A request accepted into the input register moves into the result register when that
// register is empty or being drained. Throughput: one request per cycle while i_out_stall
// is low; the input register refills in the same cycle it hands its request on. Reset
// (synchronous, active low) empties both registers, clears every axis tracker and the
// reference pose, and loads the configuration defaults.
`timescale 1ns / 1ps

module motion_oscillation_guard (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic signed [23:0]              i_pose_x,
    input  logic signed [23:0]              i_pose_y,
    input  logic signed [15:0]              i_pose_heading,
    input  logic signed [15:0]              i_vel_x,
    input  logic signed [15:0]              i_vel_y,
    input  logic signed [15:0]              i_vel_turn,
    input  logic        [31:0]              i_now_ms,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_rejected,
    output logic                            o_flag_newly_set,
    output logic                            o_flags_cleared,
    output logic        [5:0]               o_restrictions,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [mog_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mog_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // The four thresholds live here. The squared travel threshold is computed from
    // the write data and stored together with the distance setting, so the
    // per-request path only squares the pose deltas.
    logic signed [23:0]              r_reset_distance;
    logic signed [15:0]              r_reset_angle;
    logic signed [31:0]              r_reset_time;
    logic signed [15:0]              r_strafe_gate;
    logic [mog_pkg::DIST_SQ_W-1:0]   r_dist_sq;
    logic [mog_pkg::DIST_SQ_W-1:0]   n_dist_sq;

    mog_pkg::t_item   w_in_item;
    mog_pkg::t_item   w_item;
    mog_pkg::t_cfg    w_cfg;
    mog_pkg::t_result w_result;
    logic             w_item_vld;
    logic             w_out_free;
    logic             w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_distance <= mog_pkg::RST_RESET_DISTANCE;
            r_reset_angle    <= mog_pkg::RST_RESET_ANGLE;
            r_reset_time     <= mog_pkg::RST_RESET_TIME;
            r_strafe_gate    <= mog_pkg::RST_STRAFE_GATE;
            r_dist_sq        <= mog_pkg::RST_DIST_SQ;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mog_pkg::CFG_RESET_DISTANCE: begin
                        r_reset_distance <= i_cfg_data[23:0];
                        r_dist_sq        <= n_dist_sq;
                    end
                    mog_pkg::CFG_RESET_ANGLE:    r_reset_angle    <= i_cfg_data[15:0];
                    mog_pkg::CFG_RESET_TIME:     r_reset_time     <= i_cfg_data[31:0];
                    mog_pkg::CFG_STRAFE_GATE:    r_strafe_gate    <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Only a non-negative distance is ever compared, so its low 23 bits suffice.
    assign n_dist_sq = i_cfg_data[22:0] * i_cfg_data[22:0];

    assign w_cfg = '{reset_distance: r_reset_distance,
                     reset_angle:    r_reset_angle,
                     reset_time:     r_reset_time,
                     strafe_gate:    r_strafe_gate,
                     dist_sq:        r_dist_sq};

    assign w_in_item = '{mode:         i_mode,
                         pose_x:       i_pose_x,
                         pose_y:       i_pose_y,
                         pose_heading: i_pose_heading,
                         vel_x:        i_vel_x,
                         vel_y:        i_vel_y,
                         vel_turn:     i_vel_turn,
                         now_ms:       i_now_ms};

    // A held request moves on whenever the result register is empty or is
    // being drained in this cycle.
    assign w_step = w_item_vld && w_out_free;

    mog_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (w_in_item),
        .i_pop   (w_step),
        .o_valid (w_item_vld),
        .o_item  (w_item)
    );

    mog_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (w_item),
        .i_cfg       (w_cfg),
        .i_out_stall (i_out_stall),
        .o_out_free  (w_out_free),
        .o_out_valid (o_out_valid),
        .o_result    (w_result)
    );

    assign o_rejected       = w_result.rejected;
    assign o_flag_newly_set = w_result.flag_newly_set;
    assign o_flags_cleared  = w_result.flags_cleared;
    assign o_restrictions   = w_result.restrictions;

endmodule

[rtl/mog_in_reg.sv]
// Input request register with valid/stall handshake.
`timescale 1ns / 1ps

module mog_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  mog_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output mog_pkg::t_item  o_item
);

    logic           r_vld;
    logic           n_vld;
    mog_pkg::t_item r_item;
    logic           w_take;

    // The register can refill in the same cycle that it hands its request on.
    assign o_stall = r_vld && !i_pop;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        n_vld = r_vld;
        if (w_take) begin
            n_vld = 1'b1;
        end else if (i_pop) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

[rtl/mog_reset_test.sv]
// Distance, heading and elapsed-time tests against the reference pose.
`timescale 1ns / 1ps

module mog_reset_test (
    input  mog_pkg::t_item i_item,
    input  mog_pkg::t_ref  i_ref,
    input  mog_pkg::t_cfg  i_cfg,
    output logic           o_due
);

    logic signed [24:0] w_dx;
    logic signed [24:0] w_dy;
    logic signed [49:0] w_sq_x;
    logic signed [49:0] w_sq_y;
    logic        [50:0] w_sum;
    logic signed [16:0] w_dh;
    logic        [16:0] w_abs_dh;
    logic        [31:0] w_elapsed;
    logic               w_dist_hit;
    logic               w_angle_hit;
    logic               w_time_hit;

    assign w_dx   = 25'(i_item.pose_x) - 25'(i_ref.x);
    assign w_dy   = 25'(i_item.pose_y) - 25'(i_ref.y);
    assign w_sq_x = w_dx * w_dx;
    assign w_sq_y = w_dy * w_dy;
    assign w_sum  = {1'b0, $unsigned(w_sq_x)} + {1'b0, $unsigned(w_sq_y)};

    assign w_dh     = 17'(i_item.pose_heading) - 17'(i_ref.heading);
    assign w_abs_dh = w_dh[16] ? $unsigned(-w_dh) : $unsigned(w_dh);

    // Time wraps modulo 2^32; the difference is read as unsigned.
    assign w_elapsed = i_item.now_ms - i_ref.time_ms;

    // A negative threshold disables its test.
    assign w_dist_hit  = !i_cfg.reset_distance[23]
                         && (w_sum > {5'd0, i_cfg.dist_sq});
    assign w_angle_hit = !i_cfg.reset_angle[15]
                         && (w_abs_dh > {1'b0, $unsigned(i_cfg.reset_angle)});
    assign w_time_hit  = !i_cfg.reset_time[31]
                         && (w_elapsed > $unsigned(i_cfg.reset_time));

    assign o_due = w_dist_hit || w_angle_hit || w_time_hit;

endmodule

[rtl/mog_core.sv]
// Axis trackers, reference latch and result register.
`timescale 1ns / 1ps

module mog_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  mog_pkg::t_item   i_item,
    input  mog_pkg::t_cfg    i_cfg,
    input  logic             i_out_stall,
    output logic             o_out_free,
    output logic             o_out_valid,
    output mog_pkg::t_result o_result
);

    typedef struct packed {
        mog_pkg::t_sign sign;
        logic           pos_only;
        logic           neg_only;
        logic           set;
    } t_trk;

    mog_pkg::t_sign   r_sign [3];
    mog_pkg::t_sign   n_sign [3];
    logic [2:0]       r_pos;
    logic [2:0]       n_pos;
    logic [2:0]       r_neg;
    logic [2:0]       n_neg;
    mog_pkg::t_ref    r_ref;
    mog_pkg::t_ref    n_ref;
    logic             r_out_vld;
    logic             n_out_vld;
    mog_pkg::t_result r_res;
    mog_pkg::t_result n_res;

    logic signed [15:0] w_vel [3];
    t_trk               w_trk [3];
    logic [16:0]        w_abs_vx;
    logic               w_gate_ok;
    logic               w_set;
    logic               w_any_flag;
    logic               w_due;
    logic               w_clear;
    logic [5:0]         w_bits;

    function automatic t_trk track(mog_pkg::t_sign s, logic p, logic n,
                                   logic signed [15:0] v);
        t_trk t;
        t = '{sign: s, pos_only: p, neg_only: n, set: 1'b0};
        if (v[15]) begin
            if (s == mog_pkg::SIGN_POS) begin
                t.neg_only = 1'b1;
                t.set      = 1'b1;
            end
            t.sign = mog_pkg::SIGN_NEG;
        end else if (v != 16'sd0) begin
            if (s == mog_pkg::SIGN_NEG) begin
                t.pos_only = 1'b1;
                t.set      = 1'b1;
            end
            t.sign = mog_pkg::SIGN_POS;
        end
        return t;
    endfunction

    assign w_vel[0] = i_item.vel_x;
    assign w_vel[1] = i_item.vel_y;
    assign w_vel[2] = i_item.vel_turn;

    assign w_abs_vx  = i_item.vel_x[15] ? $unsigned(-(17'(i_item.vel_x)))
                                        : $unsigned(17'(i_item.vel_x));
    assign w_gate_ok = i_cfg.strafe_gate[15]
                       || (w_abs_vx <= {1'b0, $unsigned(i_cfg.strafe_gate)});

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_trk[a] = track(r_sign[a], r_pos[a], r_neg[a], w_vel[a]);
        end
    end

    assign w_set      = w_trk[0].set || (w_gate_ok && (w_trk[1].set || w_trk[2].set));
    assign w_any_flag = (|r_pos) || (|r_neg);

    mog_reset_test u_reset_test (
        .i_item (i_item),
        .i_ref  (r_ref),
        .i_cfg  (i_cfg),
        .o_due  (w_due)
    );

    // A fresh latch puts the reference at the current pose, where no test can
    // fire, so a clear only happens on steps that set nothing; the flags then
    // equal the stored ones.
    assign w_clear = w_any_flag && !w_set && w_due;

    assign o_out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_sign[a] = r_sign[a];
        end
        n_pos     = r_pos;
        n_neg     = r_neg;
        n_ref     = r_ref;
        n_res     = r_res;
        n_out_vld = r_out_vld && i_out_stall;
        w_bits    = '0;
        if (i_step) begin
            n_out_vld = 1'b1;
            if (i_item.mode == 1'(mog_pkg::MODE_SCORE)) begin
                n_res.rejected = 1'b0;
                for (int a = 0; a < 3; a++) begin
                    if ((r_pos[a] && w_vel[a][15])
                        || (r_neg[a] && !w_vel[a][15] && (w_vel[a] != 16'sd0))) begin
                        n_res.rejected = 1'b1;
                    end
                end
                n_res.flag_newly_set = 1'b0;
                n_res.flags_cleared  = 1'b0;
            end else begin
                for (int a = 0; a < 3; a++) begin
                    if ((a == 0) || w_gate_ok) begin
                        n_sign[a] = w_trk[a].sign;
                        n_pos[a]  = w_trk[a].pos_only;
                        n_neg[a]  = w_trk[a].neg_only;
                    end
                end
                if (w_set) begin
                    n_ref.x       = i_item.pose_x;
                    n_ref.y       = i_item.pose_y;
                    n_ref.heading = i_item.pose_heading;
                    n_ref.time_ms = i_item.now_ms;
                end
                if (w_clear) begin
                    for (int a = 0; a < 3; a++) begin
                        n_sign[a] = mog_pkg::SIGN_ZERO;
                    end
                    n_pos = '0;
                    n_neg = '0;
                end
                n_res.rejected       = 1'b0;
                n_res.flag_newly_set = w_set;
                n_res.flags_cleared  = w_clear;
            end
            for (int a = 0; a < 3; a++) begin
                w_bits[2*a]   = n_pos[a];
                w_bits[2*a+1] = n_neg[a];
            end
            n_res.restrictions = w_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_sign[a] <= mog_pkg::SIGN_ZERO;
            end
            r_pos     <= '0;
            r_neg     <= '0;
            r_ref     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            for (int a = 0; a < 3; a++) begin
                r_sign[a] <= n_sign[a];
            end
            r_pos     <= n_pos;
            r_neg     <= n_neg;
            r_ref     <= n_ref;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_res;

endmodule

[rtl/mog_checker.sv]
// Port-level checks for the motion oscillation guard, bound to the top level.
`timescale 1ns / 1ps

module mog_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic                            o_rejected,
    input logic                            o_flag_newly_set,
    input logic                            o_flags_cleared,
    input logic        [5:0]               o_restrictions
);

    // No result is offered in the cycle after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result offered right after reset");

    // A cleared step leaves no axis restricted.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_flags_cleared) |-> (o_restrictions == 6'd0))
        else $error("flags_cleared with restrictions left");

    // A newly set flag shows in the restrictions and never clears in the same step.
    a_set_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_flag_newly_set) |-> (o_restrictions != 6'd0 && !o_flags_cleared))
        else $error("flag_newly_set without a restriction");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_rejected)
            && $stable(o_flag_newly_set) && $stable(o_flags_cleared)
            && $stable(o_restrictions)))
        else $error("stalled result changed");

endmodule

bind motion_oscillation_guard mog_checker u_mog_checker (.*);
